// ----- rtl/tks_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thruster kill supervisor package
// Shared types, codes and constants for the supervisor and its checker.
// ----------------------------------------------------------------------------
package tks_pkg;

    localparam int THRUSTER_COUNT = 8;
    localparam int RES_MAX        = 6;
    localparam int RES_CNT_W      = 3;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;

    localparam logic [7:0]  HB_LIMIT_RST     = 8'd100;
    localparam logic [7:0]  IDLE_LIMIT_RST   = 8'd50;
    localparam logic [7:0]  STATUS_PER_RST   = 8'd100;
    localparam logic [15:0] POWER_WAIT_RST   = 16'd300;
    localparam logic [15:0] SETTLE_WAIT_RST  = 16'd200;
    localparam logic [7:0]  INPUT_STATUS_RST = 8'h80;

    typedef enum logic [1:0] {
        ACT_FAST_TICK = 2'd0,
        ACT_SLOW_TICK = 2'd1,
        ACT_KILL_MSG  = 2'd2,
        ACT_HOST_MSG  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        KMSG_SOFT_KILL   = 2'd0,
        KMSG_SOFT_UNKILL = 2'd1,
        KMSG_HEARTBEAT   = 2'd2,
        KMSG_OTHER       = 2'd3
    } t_kill_msg;

    typedef enum logic [2:0] {
        KIND_STATUS    = 3'd0,
        KIND_THRUST    = 3'd1,
        KIND_IDLE      = 3'd2,
        KIND_SOFTKILL  = 3'd3,
        KIND_POWERINIT = 3'd4,
        KIND_ESC_STOP  = 3'd5,
        KIND_HARDKILL  = 3'd6,
        KIND_UNKILL    = 3'd7
    } t_kind;

    typedef enum logic [1:0] {
        PH_DONE   = 2'd0,
        PH_POWER  = 2'd1,
        PH_SETTLE = 2'd2,
        PH_HALT   = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        CFG_HB_LIMIT    = 3'd0,
        CFG_IDLE_LIMIT  = 3'd1,
        CFG_STATUS_PER  = 3'd2,
        CFG_POWER_WAIT  = 3'd3,
        CFG_SETTLE_WAIT = 3'd4
    } t_cfg_reg;

    // soft kill source bits
    localparam int SRC_SENSOR = 2;
    localparam int SRC_HOST   = 1;
    localparam int SRC_HB     = 0;

    // input status bits
    localparam int IST_ON   = 7;
    localparam int IST_SOFT = 6;
    localparam int IST_GO   = 5;
    localparam int IST_INIT = 4;

    typedef struct packed {
        logic [1:0]  action;
        logic [1:0]  kill_msg_kind;
        logic        thrust_valid;
        logic [2:0]  thruster_index;
        logic [31:0] speed_word;
        logic        on_magnet;
        logic        soft_magnet;
        logic        go_magnet;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  kill_flags;
        logic [7:0]  input_flags;
        logic [2:0]  out_thruster;
        logic [31:0] out_speed;
        logic        last;
    } t_out_item;

endpackage

// ----- rtl/thruster_kill_supervisor_top.sv -----
`timescale 1ns / 1ps
// Timing: an item is registered on transfer and evaluated once the result buffer is free;
// its results are registered into the result buffer and presented from entry 0.
// Throughput: one item per cycle when it yields at most one result and the output is not
// stalled; else the next item waits while the result buffer drains one transfer per cycle.
// Reset (synchronous, active low) restores default limits and resets all supervisor state.
// ----------------------------------------------------------------------------
// Thruster kill supervisor
// Tracks heartbeat, soft/hard kill and the post-unkill power-up sequence,
// gates thrust commands and emits status and command frames.
// ----------------------------------------------------------------------------
module thruster_kill_supervisor_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  tks_pkg::t_in_item                i_in,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output tks_pkg::t_out_item               o_out,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [tks_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tks_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    // Configuration registers
    logic [7:0]  r_hb_limit, r_idle_limit, r_status_per;
    logic [15:0] r_power_wait, r_settle_wait;

    // Supervisor state
    logic [7:0]      r_hb_missed, r_status_wait, r_idle_count, r_ist;
    logic [15:0]     r_init_timer;
    tks_pkg::t_phase r_phase;
    logic [2:0]      r_src;
    logic            r_hard, r_ovl_last, r_go_last, r_go_pend;

    // Input stage
    logic              r_in_valid;
    tks_pkg::t_in_item r_in;

    // Result buffer: entry 0 is presented, shift on transfer
    tks_pkg::t_out_item             r_buf [tks_pkg::RES_MAX];
    logic [tks_pkg::RES_CNT_W-1:0]  r_cnt;

    // Next-state values from the evaluation of the registered item
    logic [7:0]      n_hb_missed, n_status_wait, n_idle_count, n_ist;
    logic [15:0]     n_init_timer;
    tks_pkg::t_phase n_phase;
    logic [2:0]      n_src;
    logic            n_hard, n_ovl_last, n_go_last, n_go_pend;
    tks_pkg::t_out_item             n_res [tks_pkg::RES_MAX];
    logic [tks_pkg::RES_CNT_W-1:0]  n_res_cnt;

    logic in_xfer, out_xfer, proc;
    logic do_loop, loop_tick, overall;

    function automatic tks_pkg::t_out_item f_res(
        input tks_pkg::t_kind k,
        input logic [7:0]     kf,
        input logic [7:0]     inf,
        input logic [2:0]     thr,
        input logic [31:0]    spd
    );
        tks_pkg::t_out_item r;
        r.kind         = k;
        r.kill_flags   = kf;
        r.input_flags  = inf;
        r.out_thruster = thr;
        r.out_speed    = spd;
        r.last         = 1'b0;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Handshakes. The input register frees up in the same cycle it is
    // evaluated, so a new item may transfer while results still drain.
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = (r_cnt != '0);
    assign o_out       = r_buf[0];
    assign out_xfer    = o_out_valid && i_out_ready;
    assign proc        = r_in_valid &&
                         ((r_cnt == '0) || ((r_cnt == tks_pkg::RES_CNT_W'(1)) && out_xfer));
    assign o_in_ready  = !r_in_valid || proc;
    assign in_xfer     = i_in_valid && o_in_ready;

    // ------------------------------------------------------------------
    // Single-pass evaluation of the registered item
    // ------------------------------------------------------------------
    always_comb begin
        n_hb_missed   = r_hb_missed;
        n_status_wait = r_status_wait;
        n_idle_count  = r_idle_count;
        n_ist         = r_ist;
        n_init_timer  = r_init_timer;
        n_phase       = r_phase;
        n_src         = r_src;
        n_hard        = r_hard;
        n_ovl_last    = r_ovl_last;
        n_go_last     = r_go_last;
        n_go_pend     = r_go_pend;
        n_res_cnt     = '0;
        do_loop       = 1'b0;
        loop_tick     = 1'b0;
        overall       = 1'b0;
        for (int i = 0; i < tks_pkg::RES_MAX; i++) begin
            n_res[i] = '0;
        end

        if (r_hard) begin
            // Hard-kill lock: poll the on magnet only
            if (!r_in.on_magnet) begin
                n_res[n_res_cnt] = f_res(tks_pkg::KIND_HARDKILL,
                                         {n_hard, n_ovl_last, n_src, 3'b000}, n_ist, '0, '0);
                n_res_cnt = n_res_cnt + 1'b1;
            end else begin
                n_hard = 1'b0;
                n_ist[tks_pkg::IST_ON] = 1'b1;
                n_res[n_res_cnt] = f_res(tks_pkg::KIND_UNKILL,
                                         {n_hard, n_ovl_last, n_src, 3'b000}, n_ist, '0, '0);
                n_res_cnt = n_res_cnt + 1'b1;
                n_go_pend = 1'b1;
                do_loop   = 1'b1;
                loop_tick = 1'b1;
            end
        end else begin
            do_loop = 1'b1;
            unique case (tks_pkg::t_action'(r_in.action))
                tks_pkg::ACT_FAST_TICK: begin
                    // Sample soft sensor
                    n_src[tks_pkg::SRC_SENSOR] = !r_in.soft_magnet;
                    n_ist[tks_pkg::IST_SOFT]   = r_in.soft_magnet;
                    if (n_status_wait > r_status_per) begin
                        n_status_wait = '0;
                        n_res[n_res_cnt] = f_res(tks_pkg::KIND_STATUS,
                                                 {n_hard, n_ovl_last, n_src, 3'b000},
                                                 n_ist, '0, '0);
                        n_res_cnt = n_res_cnt + 1'b1;
                    end else if (n_status_wait != 8'hFF) begin
                        n_status_wait = n_status_wait + 8'd1;
                    end
                    if (!n_src[tks_pkg::SRC_HB] && (n_hb_missed != 8'hFF)) begin
                        n_hb_missed = n_hb_missed + 8'd1;
                    end
                    if (((n_phase == tks_pkg::PH_POWER) || (n_phase == tks_pkg::PH_SETTLE))
                        && (n_init_timer != 16'hFFFF)) begin
                        n_init_timer = n_init_timer + 16'd1;
                    end
                    if (n_idle_count != 8'hFF) begin
                        n_idle_count = n_idle_count + 8'd1;
                    end
                    loop_tick = 1'b1;
                end
                tks_pkg::ACT_SLOW_TICK: begin
                    if (!r_in.on_magnet) begin
                        // Enter hard-kill lock; skip the loop pass
                        n_hard = 1'b1;
                        n_ist[tks_pkg::IST_ON] = 1'b0;
                        n_res[n_res_cnt] = f_res(tks_pkg::KIND_HARDKILL,
                                                 {n_hard, n_ovl_last, n_src, 3'b000},
                                                 n_ist, '0, '0);
                        n_res_cnt = n_res_cnt + 1'b1;
                        do_loop   = 1'b0;
                    end else begin
                        n_go_pend = 1'b1;
                        loop_tick = 1'b1;
                    end
                end
                tks_pkg::ACT_KILL_MSG: begin
                    unique case (tks_pkg::t_kill_msg'(r_in.kill_msg_kind))
                        tks_pkg::KMSG_SOFT_KILL:   n_src[tks_pkg::SRC_HOST] = 1'b1;
                        tks_pkg::KMSG_SOFT_UNKILL: n_src[tks_pkg::SRC_HOST] = 1'b0;
                        tks_pkg::KMSG_HEARTBEAT:   n_hb_missed = '0;
                        tks_pkg::KMSG_OTHER: begin
                            if ((n_phase == tks_pkg::PH_POWER) ||
                                (n_phase == tks_pkg::PH_SETTLE)) begin
                                n_phase = tks_pkg::PH_HALT;
                            end
                        end
                    endcase
                end
                tks_pkg::ACT_HOST_MSG: begin
                    n_idle_count = '0;
                    if (r_in.thrust_valid && !n_ovl_last && (n_phase == tks_pkg::PH_DONE) &&
                        ({2'b00, r_in.thruster_index} < 5'(tks_pkg::THRUSTER_COUNT))) begin
                        n_res[n_res_cnt] = f_res(tks_pkg::KIND_THRUST,
                                                 {n_hard, n_ovl_last, n_src, 3'b000}, n_ist,
                                                 r_in.thruster_index, r_in.speed_word);
                        n_res_cnt = n_res_cnt + 1'b1;
                    end
                end
            endcase
        end

        // Supervision loop pass
        if (do_loop) begin
            if (loop_tick && (n_idle_count >= r_idle_limit)) begin
                n_res[n_res_cnt] = f_res(tks_pkg::KIND_IDLE,
                                         {n_hard, n_ovl_last, n_src, 3'b000}, n_ist, '0, '0);
                n_res_cnt = n_res_cnt + 1'b1;
            end
            n_src[tks_pkg::SRC_HB] = (n_hb_missed > r_hb_limit);
            if (n_go_pend) begin
                if (r_in.go_magnet != n_go_last) begin
                    n_ist[tks_pkg::IST_GO] = r_in.go_magnet;
                    n_status_wait = '0;
                    n_res[n_res_cnt] = f_res(tks_pkg::KIND_STATUS,
                                             {n_hard, n_ovl_last, n_src, 3'b000}, n_ist, '0, '0);
                    n_res_cnt = n_res_cnt + 1'b1;
                    n_go_last = r_in.go_magnet;
                end
                n_go_pend = 1'b0;
            end
            overall = (n_src != '0);
            if (overall && !n_ovl_last) begin
                n_ovl_last = 1'b1;
                n_ist[tks_pkg::IST_INIT] = 1'b0;
                n_phase = tks_pkg::PH_HALT;
                n_status_wait = '0;
                n_res[n_res_cnt] = f_res(tks_pkg::KIND_SOFTKILL,
                                         {n_hard, n_ovl_last, n_src, 3'b000}, n_ist, '0, '0);
                n_res_cnt = n_res_cnt + 1'b1;
            end else if (!overall && n_ovl_last) begin
                n_ovl_last = 1'b0;
                n_phase = tks_pkg::PH_POWER;
                n_init_timer = '0;
                n_ist[tks_pkg::IST_INIT] = 1'b1;
                n_status_wait = '0;
                n_res[n_res_cnt] = f_res(tks_pkg::KIND_POWERINIT,
                                         {n_hard, n_ovl_last, n_src, 3'b000}, n_ist, '0, '0);
                n_res_cnt = n_res_cnt + 1'b1;
            end
            if ((n_phase == tks_pkg::PH_POWER) && (n_init_timer >= r_power_wait)) begin
                n_phase = tks_pkg::PH_SETTLE;
                n_init_timer = '0;
                n_res[n_res_cnt] = f_res(tks_pkg::KIND_ESC_STOP,
                                         {n_hard, n_ovl_last, n_src, 3'b000}, n_ist, '0, '0);
                n_res_cnt = n_res_cnt + 1'b1;
            end
            if ((n_phase == tks_pkg::PH_SETTLE) && (n_init_timer >= r_settle_wait)) begin
                n_phase = tks_pkg::PH_DONE;
                n_init_timer = '0;
                n_ist[tks_pkg::IST_INIT] = 1'b0;
                n_status_wait = '0;
                n_res[n_res_cnt] = f_res(tks_pkg::KIND_STATUS,
                                         {n_hard, n_ovl_last, n_src, 3'b000}, n_ist, '0, '0);
                n_res_cnt = n_res_cnt + 1'b1;
            end
        end

        // Mark the final result of the item
        if (n_res_cnt != '0) begin
            n_res[n_res_cnt - 1'b1].last = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Control and state registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hb_limit    <= tks_pkg::HB_LIMIT_RST;
            r_idle_limit  <= tks_pkg::IDLE_LIMIT_RST;
            r_status_per  <= tks_pkg::STATUS_PER_RST;
            r_power_wait  <= tks_pkg::POWER_WAIT_RST;
            r_settle_wait <= tks_pkg::SETTLE_WAIT_RST;
            r_hb_missed   <= '0;
            r_status_wait <= '0;
            r_idle_count  <= '0;
            r_init_timer  <= '0;
            r_phase       <= tks_pkg::PH_DONE;
            r_src         <= '0;
            r_hard        <= 1'b0;
            r_ovl_last    <= 1'b0;
            r_go_last     <= 1'b0;
            r_go_pend     <= 1'b0;
            r_ist         <= tks_pkg::INPUT_STATUS_RST;
            r_in_valid    <= 1'b0;
            r_cnt         <= '0;
        end else begin
            // Configuration write; indexes past the list are dropped
            if (i_cfg_valid) begin
                case (tks_pkg::t_cfg_reg'(i_cfg_index))
                    tks_pkg::CFG_HB_LIMIT:    r_hb_limit    <= i_cfg_data[7:0];
                    tks_pkg::CFG_IDLE_LIMIT:  r_idle_limit  <= i_cfg_data[7:0];
                    tks_pkg::CFG_STATUS_PER:  r_status_per  <= i_cfg_data[7:0];
                    tks_pkg::CFG_POWER_WAIT:  r_power_wait  <= i_cfg_data;
                    tks_pkg::CFG_SETTLE_WAIT: r_settle_wait <= i_cfg_data;
                    default: ;
                endcase
            end

            // Hold the input register until it is evaluated
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end

            // Commit the pass and load its results, or advance the buffer
            if (proc) begin
                r_hb_missed   <= n_hb_missed;
                r_status_wait <= n_status_wait;
                r_idle_count  <= n_idle_count;
                r_init_timer  <= n_init_timer;
                r_phase       <= n_phase;
                r_src         <= n_src;
                r_hard        <= n_hard;
                r_ovl_last    <= n_ovl_last;
                r_go_last     <= n_go_last;
                r_go_pend     <= n_go_pend;
                r_ist         <= n_ist;
                r_cnt         <= n_res_cnt;
            end else if (out_xfer) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in <= i_in;
        end
        if (proc) begin
            for (int i = 0; i < tks_pkg::RES_MAX; i++) begin
                r_buf[i] <= n_res[i];
            end
        end else if (out_xfer) begin
            for (int i = 0; i < tks_pkg::RES_MAX - 1; i++) begin
                r_buf[i] <= r_buf[i+1];
            end
        end
    end

endmodule

// ----- rtl/tks_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thruster kill supervisor checker
// Port-level properties of the supervisor result stream.
// ----------------------------------------------------------------------------
module tks_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_out_valid,
    input logic                             i_out_ready,
    input tks_pkg::t_out_item               o_out
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out)))
        else $error("stalled result changed");

    // Hard kill frames show the lock and the missing on magnet
    a_hardkill_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.kind == tks_pkg::KIND_HARDKILL)) |->
        (o_out.kill_flags[7] && !o_out.input_flags[tks_pkg::IST_ON] && o_out.last))
        else $error("hard kill frame flags wrong");

    // Unkill frames show the lock released
    a_unkill_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.kind == tks_pkg::KIND_UNKILL)) |->
        (!o_out.kill_flags[7] && o_out.input_flags[tks_pkg::IST_ON]))
        else $error("unkill frame flags wrong");

    // Only thrust frames carry a thruster and speed
    a_non_thrust_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.kind != tks_pkg::KIND_THRUST)) |->
        ((o_out.out_speed == '0) && (o_out.out_thruster == '0)))
        else $error("payload on non-thrust frame");

    // Thrust passes only when not soft killed and not initializing
    a_thrust_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.kind == tks_pkg::KIND_THRUST)) |->
        (!o_out.kill_flags[6] && !o_out.kill_flags[7] && !o_out.input_flags[tks_pkg::IST_INIT]))
        else $error("thrust forwarded while gated");

endmodule

bind thruster_kill_supervisor_top tks_checker u_tks_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
